// ===== sv/tpdc_pkg.sv =====
// Shared types and constants for the triac phase dimming controller.
// No dependencies; imported by tpdc_ctrl, tpdc_datapath and the top level.
package tpdc_pkg;

    // Phase slots per half cycle held in each dim table (8..16)
    localparam int PHASE_SLOTS = 11;
    localparam int SLOT_W      = $clog2(PHASE_SLOTS);

    // Brightness at or above this level is fully on
    localparam logic [7:0] FULL_LEVEL = 8'd7;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_ENABLE   = 4'd1,
        OP_DISABLE  = 4'd2,
        OP_DIM      = 4'd3,
        OP_ALLOC    = 4'd4,
        OP_FREE     = 4'd5,
        OP_OVR_EN   = 4'd6,
        OP_OVR_DIS  = 4'd7,
        OP_OVR_DIM  = 4'd8
    } t_op;

    // Controller to datapath command
    typedef struct packed {
        logic exec;     // apply the input word, load result register
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;  // word being presented is a tick
    } t_dp_stat;

endpackage

// ===== sv/tpdc_ctrl.sv =====
// Handshake controller: tracks whether the result register holds a word.
// Depends on tpdc_pkg.
module tpdc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  tpdc_pkg::t_dp_stat  i_stat,
    output tpdc_pkg::t_ctl_cmd  o_cmd
);
    import tpdc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // New word may enter while the held result is being taken
    assign o_ready   = (r_state == ST_IDLE) || i_ready;
    assign o_valid   = (r_state == ST_HOLD);
    assign accept    = i_valid && o_ready;
    assign o_cmd.exec = accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (accept)       n_state = ST_HOLD;
                else if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_accept_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_HOLD))
        else $error("accepted word did not produce a result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD && i_ready && !i_valid) |=> (r_state == ST_IDLE))
        else $error("taken result not released");

    a_tick_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && i_stat.is_tick) |=> o_valid)
        else $error("tick word lost");
`endif

endmodule

// ===== sv/tpdc_datapath.sv =====
// Masks, phase tables, latch and result register for the dimming controller.
// Depends on tpdc_pkg.
module tpdc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpdc_pkg::t_ctl_cmd  i_cmd,
    output tpdc_pkg::t_dp_stat  o_stat,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic [3:0]          i_op,
    input  logic [7:0]          i_string_mask,
    input  logic [7:0]          i_brightness,
    input  logic [3:0]          i_phase,
    output logic [7:0]          o_latch,
    output logic [7:0]          o_pulse,
    output logic                o_latch_written
);
    import tpdc_pkg::*;

    logic       r_allow;
    logic [7:0] r_norm_on, n_norm_on;
    logic [7:0] r_alloc, n_alloc;
    logic [7:0] r_ovr_on, n_ovr_on;
    logic [7:0] r_latch, n_latch;
    logic [7:0] r_ntab [PHASE_SLOTS];
    logic [7:0] n_ntab [PHASE_SLOTS];
    logic [7:0] r_otab [PHASE_SLOTS];
    logic [7:0] n_otab [PHASE_SLOTS];
    logic [7:0] r_pulse, n_pulse;
    logic       r_written, n_written;

    t_op        op;
    logic       lvl_zero, lvl_part;
    logic [2:0] dim_slot;
    logic       phase_ok;
    logic [7:0] tick_bits;
    logic [7:0] take;

    assign op       = t_op'(i_op);
    assign o_stat.is_tick = (op == OP_TICK);
    assign lvl_zero = (i_brightness == 8'd0);
    assign lvl_part = !lvl_zero && (i_brightness < FULL_LEVEL) && r_allow;
    assign dim_slot = 3'(FULL_LEVEL - i_brightness);
    assign phase_ok = ({1'b0, i_phase} < 5'(PHASE_SLOTS));
    assign tick_bits = phase_ok ? (r_ntab[i_phase[SLOT_W-1:0]]
                                 | r_otab[i_phase[SLOT_W-1:0]]) : 8'd0;
    assign take     = i_string_mask & ~r_alloc;

    always_comb begin
        n_norm_on = r_norm_on;
        n_alloc   = r_alloc;
        n_ovr_on  = r_ovr_on;
        n_ntab    = r_ntab;
        n_otab    = r_otab;
        n_pulse   = 8'd0;
        n_written = 1'b1;
        case (op)
            OP_TICK: begin
                n_pulse   = tick_bits;
                n_written = (tick_bits != 8'd0);
            end
            OP_ENABLE, OP_DISABLE, OP_DIM: begin
                for (int i = 0; i < PHASE_SLOTS; i++) begin
                    n_ntab[i] = r_ntab[i] & ~i_string_mask;
                    if (op == OP_DIM && lvl_part && i == int'(dim_slot))
                        n_ntab[i] = n_ntab[i] | i_string_mask;
                end
                if (op == OP_ENABLE)
                    n_norm_on = r_norm_on | i_string_mask;
                else if (op == OP_DIM && !lvl_zero && !lvl_part)
                    n_norm_on = r_norm_on | i_string_mask;
                else
                    n_norm_on = r_norm_on & ~i_string_mask;
            end
            OP_ALLOC: begin
                n_alloc  = r_alloc | take;
                n_ovr_on = r_ovr_on & ~take;
            end
            OP_FREE, OP_OVR_EN, OP_OVR_DIS, OP_OVR_DIM: begin
                for (int i = 0; i < PHASE_SLOTS; i++) begin
                    n_otab[i] = r_otab[i] & ~i_string_mask;
                    if (op == OP_OVR_DIM && lvl_part && i == int'(dim_slot))
                        n_otab[i] = n_otab[i] | i_string_mask;
                end
                if (op == OP_FREE)
                    n_alloc = r_alloc & ~i_string_mask;
                if (op == OP_OVR_EN)
                    n_ovr_on = r_ovr_on | i_string_mask;
                else if (op == OP_OVR_DIM && !lvl_zero && !lvl_part)
                    n_ovr_on = r_ovr_on | i_string_mask;
                else
                    n_ovr_on = r_ovr_on & ~i_string_mask;
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    // Commands rewrite the steady latch; ticks and unused codes keep it
    always_comb begin
        n_latch = r_latch;
        if (op != OP_TICK && n_written)
            n_latch = (n_norm_on & ~n_alloc) | n_ovr_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow   <= 1'b1;
            r_norm_on <= 8'd0;
            r_alloc   <= 8'd0;
            r_ovr_on  <= 8'd0;
            r_latch   <= 8'd0;
            for (int i = 0; i < PHASE_SLOTS; i++) begin
                r_ntab[i] <= 8'd0;
                r_otab[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) r_allow <= i_cfg_data;
            if (i_cmd.exec) begin
                r_norm_on <= n_norm_on;
                r_alloc   <= n_alloc;
                r_ovr_on  <= n_ovr_on;
                r_latch   <= n_latch;
                r_ntab    <= n_ntab;
                r_otab    <= n_otab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pulse   <= n_pulse;
            r_written <= n_written;
        end
    end

    assign o_latch         = r_latch;
    assign o_pulse         = r_pulse;
    assign o_latch_written = r_written;

`ifndef SYNTHESIS
    a_tick_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && op == OP_TICK) |=> (r_latch == $past(r_latch)))
        else $error("tick changed the steady latch");

    a_tick_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && op == OP_TICK) |=> (r_written == (r_pulse != 8'd0)))
        else $error("tick write flag disagrees with pulse");

    a_cmd_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && op != OP_TICK && i_op <= OP_OVR_DIM)
        |=> (r_latch == ((r_norm_on & ~r_alloc) | r_ovr_on)) && r_written
            && (r_pulse == 8'd0))
        else $error("command did not refresh the latch");
`endif

endmodule

// ===== sv/triac_phase_dimming_controller.sv =====
// Top level of the triac phase dimming controller for eight lamp strings.
// Depends on tpdc_pkg, tpdc_ctrl and tpdc_datapath.
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------
// input    | in        | i_valid / o_ready   | i_op, i_string_mask, i_brightness, i_phase
// result   | out       | o_valid / i_ready   | o_latch, o_pulse, o_latch_written
// config   | in        | i_cfg_we            | i_cfg_data (allow_dimming)
//
// Each word is resolved combinationally: masks and both phase tables are flops,
// so the result is registered on the accept edge and shown the next cycle.
// Sustained rate is one word per cycle while results are taken; the result
// register is the only buffer, and a new word is taken in the same cycle the
// held one is taken. A stall on the result side holds o_ready low until the
// result is taken. Synchronous active-low reset clears all masks, tables and
// the latch, and sets allow_dimming; no clearing pass is needed.
module triac_phase_dimming_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_op,
    input  logic [7:0] i_string_mask,
    input  logic [7:0] i_brightness,
    input  logic [3:0] i_phase,
    // result words
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_latch,
    output logic [7:0] o_pulse,
    output logic       o_latch_written,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);
    import tpdc_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Handshake and result occupancy
    tpdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // String masks, phase tables, latch and result register
    tpdc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_string_mask   (i_string_mask),
        .i_brightness    (i_brightness),
        .i_phase         (i_phase),
        .o_latch         (o_latch),
        .o_pulse         (o_pulse),
        .o_latch_written (o_latch_written)
    );

endmodule

// ===== test/triac_phase_dimming_controller_tb.sv =====
// Self-checking testbench for triac_phase_dimming_controller: directed and random words,
// a cycle-level predictor of masks, phase tables and latch, and a result scoreboard.
// Depends on tpdc_pkg and the triac_phase_dimming_controller RTL.
`timescale 1ns / 100ps

module triac_phase_dimming_controller_tb;
    import tpdc_pkg::*;

    // Op codes past OP_OVR_DIM are ignored by the block
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // Table/on-mask selector for the predictor
    localparam int SIDE_NORMAL   = 0;
    localparam int SIDE_OVERRIDE = 1;

    localparam int RANDOM_WORDS = 1800;

    typedef struct packed {
        logic [7:0] latch;
        logic [7:0] pulse;
        logic       written;
    } t_lamp_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [3:0] i_op = '0;
    logic [7:0] i_string_mask = '0;
    logic [7:0] i_brightness = '0;
    logic [3:0] i_phase = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_latch;
    logic [7:0] o_pulse;
    logic       o_latch_written;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_data = 1'b0;

    // Predictor state: on-masks and phase tables per side, allocation, steady latch
    logic [7:0] on_mask [2];
    logic [7:0] dim_tbl [2][PHASE_SLOTS];
    logic [7:0] ovr_alloc;
    logic [7:0] latch_q;
    logic       dim_allowed;

    t_lamp_out  lamp_out_q[$];     // predicted result words, oldest first
    int         mismatch_cnt = 0;
    bit         bubbles_on = 1'b0; // random gaps on both channels
    int         sink_hold_cycles = 0;

    // Single config register (allow_dimming): we/data only
    triac_phase_dimming_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_string_mask   (i_string_mask),
        .i_brightness    (i_brightness),
        .i_phase         (i_phase),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_latch         (o_latch),
        .o_pulse         (o_pulse),
        .o_latch_written (o_latch_written),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generous hard stop; a healthy run ends far sooner
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Pull strings out of every slot of one side's table
    function automatic void clear_slots(int side, logic [7:0] mask);
        for (int s = 0; s < PHASE_SLOTS; s++)
            dim_tbl[side][s] &= ~mask;
    endfunction

    // Dim rule shared by normal and override: strings go off first, then
    // level 0 stays off, 1..6 (dimming allowed) lands in slot 7-level,
    // anything else is fully on.
    function automatic void apply_dim(int side, logic [7:0] mask, logic [7:0] level);
        int slot;
        clear_slots(side, mask);
        on_mask[side] &= ~mask;
        if (level != 8'd0) begin
            if (level < FULL_LEVEL && dim_allowed) begin
                slot = int'(FULL_LEVEL - level);
                if (slot < PHASE_SLOTS)
                    dim_tbl[side][slot] |= mask;
            end else begin
                on_mask[side] |= mask;
            end
        end
    endfunction

    function automatic t_lamp_out predict_lamp_word(logic [3:0] op, logic [7:0] mask,
                                                    logic [7:0] level, logic [3:0] ph);
        t_lamp_out res;
        logic [7:0] take;
        res.pulse   = '0;
        res.written = 1'b1;
        case (op)
            OP_TICK: begin
                // phases past the table read as an empty slot
                if (ph < PHASE_SLOTS)
                    res.pulse = dim_tbl[SIDE_NORMAL][ph] | dim_tbl[SIDE_OVERRIDE][ph];
                res.written = (res.pulse != 8'd0);
            end
            OP_ENABLE: begin
                clear_slots(SIDE_NORMAL, mask);
                on_mask[SIDE_NORMAL] |= mask;
            end
            OP_DISABLE: begin
                clear_slots(SIDE_NORMAL, mask);
                on_mask[SIDE_NORMAL] &= ~mask;
            end
            OP_DIM:     apply_dim(SIDE_NORMAL, mask, level);
            OP_ALLOC: begin
                // only strings not yet allocated; override table untouched
                take = mask & ~ovr_alloc;
                ovr_alloc |= take;
                on_mask[SIDE_OVERRIDE] &= ~take;
            end
            OP_FREE: begin
                clear_slots(SIDE_OVERRIDE, mask);
                ovr_alloc &= ~mask;
                on_mask[SIDE_OVERRIDE] &= ~mask;
            end
            OP_OVR_EN: begin
                clear_slots(SIDE_OVERRIDE, mask);
                on_mask[SIDE_OVERRIDE] |= mask;
            end
            OP_OVR_DIS: begin
                clear_slots(SIDE_OVERRIDE, mask);
                on_mask[SIDE_OVERRIDE] &= ~mask;
            end
            OP_OVR_DIM: apply_dim(SIDE_OVERRIDE, mask, level);
            default:    res.written = 1'b0;
        endcase
        if (op >= OP_ENABLE && op <= OP_OVR_DIM)
            latch_q = (on_mask[SIDE_NORMAL] & ~ovr_alloc) | on_mask[SIDE_OVERRIDE];
        res.latch = latch_q;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int rand_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Offer one word and hold it until taken; called in the step of a rising edge.
    // Valid is left high on return so back-to-back words need no extra toggle.
    task automatic send_word(logic [3:0] op, logic [7:0] mask, logic [7:0] level,
                             logic [3:0] ph);
        int gap;
        gap = (bubbles_on && $urandom_range(0, 2) == 0) ? rand_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_string_mask <= mask;
        i_brightness  <= level;
        i_phase       <= ph;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        lamp_out_q.push_back(predict_lamp_word(op, mask, level, ph));
    endtask

    // Config writes happen only with the block drained, after an extra idle margin.
    task automatic write_allow_dimming(logic val);
        i_valid <= 1'b0;
        while (lamp_out_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_data <= val;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dim_allowed = val;
    endtask

    // Result side ready: long holds requested by a test, else random bubbles
    initial begin : result_sink
        int gap_left;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                i_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_ready <= 1'b0;
            end else if (bubbles_on && $urandom_range(0, 3) == 0) begin
                gap_left = rand_gap() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Scoreboard: every result word against the oldest prediction
    always @(posedge i_clk) begin
        t_lamp_out want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (lamp_out_q.size() == 0) begin
                $display("%0t: unexpected result word latch=%h pulse=%h written=%b",
                         $time, o_latch, o_pulse, o_latch_written);
                mismatch_cnt++;
            end else begin
                want = lamp_out_q.pop_front();
                if (o_latch !== want.latch) begin
                    $display("%0t: latch expected %h actual %h", $time, want.latch, o_latch);
                    mismatch_cnt++;
                end
                if (o_pulse !== want.pulse) begin
                    $display("%0t: pulse expected %h actual %h", $time, want.pulse, o_pulse);
                    mismatch_cnt++;
                end
                if (o_latch_written !== want.written) begin
                    $display("%0t: latch_written expected %b actual %b",
                             $time, want.written, o_latch_written);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh from reset: empty tables, zero latch, unused ops ignored
    task automatic test_reset_state();
        send_word(OP_TICK, 8'h00, 8'h00, 4'd0);
        send_word(OP_UNUSED_HI, 8'hFF, 8'hFF, 4'hF);
    endtask

    // Every command, dim levels at the edges, allocation overlap, tick phases
    // across the table, past its end and at the last slot
    task automatic test_commands_and_ticks();
        send_word(OP_ENABLE,  8'hFF, 8'h00, 4'd0);
        send_word(OP_DISABLE, 8'h0F, 8'h00, 4'd0);
        send_word(OP_DIM,     8'h01, 8'd1,   4'd0);  // slot 6
        send_word(OP_DIM,     8'h02, 8'd6,   4'd0);  // slot 1
        send_word(OP_DIM,     8'h04, 8'd0,   4'd0);  // off
        send_word(OP_DIM,     8'h08, 8'd7,   4'd0);  // full
        send_word(OP_DIM,     8'h10, 8'd255, 4'd0);  // full
        send_word(OP_ALLOC,   8'hF0, 8'h00, 4'd0);
        send_word(OP_ALLOC,   8'hFF, 8'h00, 4'd0);   // partly already held
        send_word(OP_OVR_DIM, 8'h80, 8'd3,   4'd0);  // override slot 4
        send_word(OP_OVR_EN,  8'h40, 8'h00, 4'd0);
        send_word(OP_OVR_DIS, 8'h40, 8'h00, 4'd0);
        send_word(OP_TICK,    8'h00, 8'h00, 4'd6);
        send_word(OP_TICK,    8'hFF, 8'hFF, 4'd1);
        send_word(OP_TICK,    8'h00, 8'h00, 4'd4);
        send_word(OP_TICK,    8'h00, 8'h00, 4'd0);
        send_word(OP_TICK,    8'h00, 8'h00, 4'(PHASE_SLOTS - 1));
        send_word(OP_TICK,    8'h00, 8'h00, 4'(PHASE_SLOTS));
        send_word(OP_TICK,    8'h00, 8'h00, 4'hF);
        send_word(OP_FREE,    8'hFF, 8'h00, 4'd0);
        send_word(OP_UNUSED_LO, 8'h55, 8'd3, 4'd4);
    endtask

    // With dimming off, any nonzero level drives strings fully on
    task automatic test_dimming_disabled();
        write_allow_dimming(1'b0);
        send_word(OP_DIM,     8'h03, 8'd1, 4'd0);
        send_word(OP_OVR_DIM, 8'h30, 8'd6, 4'd0);
        send_word(OP_TICK,    8'h00, 8'h00, 4'd6);
        write_allow_dimming(1'b1);
    endtask

    // Result side stalls long while words keep coming; input must back up
    task automatic test_output_stall();
        bubbles_on       = 1'b0;
        sink_hold_cycles = 80;
        for (int i = 0; i < 24; i++)
            send_word(4'($urandom_range(int'(OP_TICK), int'(OP_OVR_DIM))),
                      8'($urandom), 8'($urandom_range(0, 8)),
                      4'($urandom_range(0, PHASE_SLOTS - 1)));
    endtask

    // Mostly meaningful traffic: frequent ticks inside the table, dim levels
    // near the interesting range; some full-range noise and unused ops.
    // Config and idling style change between segments.
    task automatic test_random_traffic(int n_words);
        logic [3:0] op;
        logic [7:0] mask;
        logic [7:0] level;
        logic [3:0] ph;
        int         r;
        for (int i = 0; i < n_words; i++) begin
            if (i % 300 == 0) begin
                if (i != 0)
                    write_allow_dimming(1'($urandom_range(0, 1)));
                bubbles_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 35)
                op = OP_TICK;
            else if (r < 95)
                op = 4'($urandom_range(int'(OP_ENABLE), int'(OP_OVR_DIM)));
            else
                op = 4'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
            mask  = ($urandom_range(0, 3) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
            level = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8)) : 8'($urandom);
            ph    = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, PHASE_SLOTS - 1))
                                               : 4'($urandom);
            send_word(op, mask, level, ph);
        end
    endtask

    initial begin
        on_mask     = '{default: '0};
        dim_tbl     = '{default: '{default: '0}};
        ovr_alloc   = '0;
        latch_q     = '0;
        dim_allowed = 1'b1;   // register comes out of reset set

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_commands_and_ticks();
        test_dimming_disabled();
        test_output_stall();
        test_random_traffic(RANDOM_WORDS);

        // Drain, then wait for anything stray to show up
        i_valid    <= 1'b0;
        bubbles_on = 1'b0;
        while (lamp_out_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
